@@ hdl/rotated_billboard_quad_expander_defines.svh @@
// ----------------------------------------------------------------------------
// rotated billboard quad expander assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet during reset
// ----------------------------------------------------------------------------
`ifndef ROTATED_BILLBOARD_QUAD_EXPANDER_DEFINES_SVH
`define ROTATED_BILLBOARD_QUAD_EXPANDER_DEFINES_SVH

// same-cycle implication
`define RBQE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBQE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rbqe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbqe_pkg
// types, register codes and the quarter-wave sine/cosine table
// ----------------------------------------------------------------------------
package rbqe_pkg;

  localparam int MAX_QUADS        = 65536;
  localparam int TRIG_TABLE_DEPTH = 1024;
  localparam int TRIG_AW          = $clog2(TRIG_TABLE_DEPTH);
  localparam int TRIG_QTR         = TRIG_TABLE_DEPTH / 4;
  localparam int TRIG_QW          = TRIG_AW - 2;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_UP_VECTOR     = 3'd0;
  localparam cfg_idx_t REG_RIGHT_VECTOR  = 3'd1;
  localparam cfg_idx_t REG_INTERP_FACTOR = 3'd2;
  localparam cfg_idx_t REG_CURRENT_TIME  = 3'd3;
  localparam cfg_idx_t REG_ADDITIVE_MODE = 3'd4;

  typedef struct packed {
    logic [47:0] now_position;
    logic [47:0] prev_position;
    logic [15:0] spin_angle;
    logic [15:0] half_size;
    logic [23:0] colour_rgb;
    logic [7:0]  opacity;
    logic        fading_in;
    logic [31:0] birth_time;
    logic [31:0] death_time;
    logic        final_particle;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] corner_x;
    logic signed [15:0] corner_y;
    logic signed [15:0] corner_z;
    logic               tex_s;
    logic               tex_t;
    logic [23:0]        vertex_rgb;
    logic [7:0]         vertex_alpha;
    logic [15:0]        life_fraction;
    logic               quad_last;
    logic [15:0]        quad_index;
  } out_rsp_t;

  // entry r holds {sin, cos} of the first quadrant as Q1.14
  typedef logic [TRIG_QTR-1:0][31:0] trig_rom_t;

  // shift-subtract quotient for the table build
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    longint unsigned x;
    longint unsigned ts;
    longint unsigned tc;
    longint ss;
    longint cs;
    longint sr;
    longint cr;
    rom = '0;
    for (int r = 0; r < TRIG_QTR; r++) begin
      x  = (HALF_PI_Q30 * longint'(4 * r)) >> TRIG_AW;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      cs = longint'(tc);
      for (int n = 1; n <= 8; n++) begin
        ts = (ts * x) >> 30;
        ts = udiv64(ts, 64'(2 * n));
        ts = (ts * x) >> 30;
        ts = udiv64(ts, 64'(2 * n + 1));
        tc = (tc * x) >> 30;
        tc = udiv64(tc, 64'(2 * n - 1));
        tc = (tc * x) >> 30;
        tc = udiv64(tc, 64'(2 * n));
        if (n[0]) begin
          ss = ss - longint'(ts);
          cs = cs - longint'(tc);
        end else begin
          ss = ss + longint'(ts);
          cs = cs + longint'(tc);
        end
      end
      sr = (ss >= 0) ? ((ss + 32768) >>> 16) : -((-ss + 32768) >>> 16);
      cr = (cs >= 0) ? ((cs + 32768) >>> 16) : -((-cs + 32768) >>> 16);
      rom[r] = {16'(sr), 16'(cr)};
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG_ROM = build_trig_rom();

endpackage

@@ hdl/rotated_billboard_quad_expander.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_billboard_quad_expander
// expands one particle request into four camera-facing corner vertices
// ----------------------------------------------------------------------------
// usage:
//   particle requests enter on in_valid_i / in_stall_o / in_req_i, vertices
//   leave on out_valid_o / out_stall_i / out_rsp_o, four per live particle in
//   corner order 00, 01, 11, 10 with quad_last on the fourth.
//   camera vectors, interpolation factor, time and blend mode are written on
//   cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i; the user must write
//   them only while idle, the block does not enforce it. dead particles are
//   dropped at the input in the cycle they are taken; a final_particle request
//   restarts the quad index either way.
//   throughput: one vertex per cycle while the output is not stalled, set by
//   the single vertex output port.
//   six register stages (capture, blend and table, rotate products, sums,
//   size products, corners) with a 4-bit-per-stage divider for the life
//   fraction, then a vertex register that walks the four corners.
//   a stall on the output freezes the vertex register and backs up through
//   the stages, filling empty slots first; nothing is lost or repeated.
//   reset clears all stage valids, the quad count and the configuration, but sets the interpolation factor to 256.
// ----------------------------------------------------------------------------
`include "rotated_billboard_quad_expander_defines.svh"

module rotated_billboard_quad_expander (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rbqe_pkg::in_req_t          in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rbqe_pkg::out_rsp_t         out_rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  rbqe_pkg::cfg_idx_t         cfg_index_i,
  input  logic [rbqe_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rbqe_pkg::*;

  function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int sh);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // configuration
  logic [47:0] up_q, right_q;
  logic [8:0]  interp_q;
  logic [31:0] cur_q;
  logic        additive_q;
  logic [8:0]  f_eff;

  // control
  logic [6:1]  v_q;
  logic [6:1]  en;
  logic        exp_valid_q;
  logic [1:0]  cnt_q;
  logic        exp_free;
  logic [15:0] quad_cnt_q;
  logic        in_acc;
  logic        in_live;

  assign cfg_ready_o = 1'b1;
  assign f_eff       = (interp_q > 9'd256) ? 9'd256 : interp_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_live     = in_req_i.death_time > cur_q;
  assign exp_free    = !exp_valid_q || ((cnt_q == 2'd3) && !out_stall_i);
  assign in_stall_o  = !en[1];

  always_comb begin
    en[6] = !v_q[6] || exp_free;
    for (int i = 5; i >= 1; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  // stage 1: captured request
  in_req_t     s1_q;
  logic [15:0] s1_idx_q;

  // stage 2: blended position, trig, alpha, divider start
  logic signed [15:0] s2_pos_d [3], s2_pos_q [3];
  logic signed [15:0] s2_sn_d, s2_cs_d, s2_sn_q, s2_cs_q;
  logic [7:0]  s2_alpha_d, s2_alpha_q;
  logic [15:0] s2_size_q, s2_idx_q;
  logic [23:0] s2_rgb_q;
  logic [31:0] s2_rem_d, s2_rem_q, s2_den_d, s2_den_q;
  logic [15:0] s2_quo_d, s2_quo_q;
  logic        s2_done_d, s2_done_q;

  // stage 3: rotation products
  logic signed [31:0] s3_rs_d [3], s3_uc_d [3], s3_rc_d [3], s3_us_d [3];
  logic signed [31:0] s3_rs_q [3], s3_uc_q [3], s3_rc_q [3], s3_us_q [3];
  logic signed [15:0] s3_pos_q [3];
  logic [7:0]  s3_alpha_q;
  logic [15:0] s3_size_q, s3_idx_q;
  logic [23:0] s3_rgb_q;
  logic [31:0] s3_rem_d, s3_rem_q, s3_den_q;
  logic [15:0] s3_quo_d, s3_quo_q;
  logic        s3_done_q;

  // stage 4: u+r and u-r
  logic signed [33:0] s4_sum_d [3], s4_dif_d [3], s4_sum_q [3], s4_dif_q [3];
  logic signed [15:0] s4_pos_q [3];
  logic [7:0]  s4_alpha_q;
  logic [15:0] s4_size_q, s4_idx_q;
  logic [23:0] s4_rgb_q;
  logic [31:0] s4_rem_d, s4_rem_q, s4_den_q;
  logic [15:0] s4_quo_d, s4_quo_q;
  logic        s4_done_q;

  // stage 5: offsets scaled by size
  logic signed [50:0] s5_a_d [3], s5_b_d [3], s5_a_q [3], s5_b_q [3];
  logic signed [15:0] s5_pos_q [3];
  logic [7:0]  s5_alpha_q;
  logic [15:0] s5_idx_q;
  logic [23:0] s5_rgb_q;
  logic [31:0] s5_rem_d, s5_rem_q, s5_den_q;
  logic [15:0] s5_quo_d, s5_quo_q;
  logic        s5_done_q;

  // stage 6: finished corners
  logic signed [15:0] s6_c_d [4][3], s6_c_q [4][3];
  logic [7:0]  s6_alpha_q;
  logic [15:0] s6_idx_q, s6_life_d, s6_life_q;
  logic [23:0] s6_rgb_q;

  // vertex register
  logic signed [15:0] ex_c_q [4][3];
  logic [7:0]  ex_alpha_q;
  logic [15:0] ex_idx_q, ex_life_q;
  logic [23:0] ex_rgb_q;

  // four restoring division steps
  function automatic logic [47:0] div4(logic [31:0] rem, logic [15:0] quo,
                                       logic [31:0] den, logic done);
    logic [32:0] r2;
    logic [31:0] r;
    logic [15:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < 4; i++) begin
      r2 = {r, 1'b0};
      if (r2 >= {1'b0, den}) begin
        r = 32'(r2 - {1'b0, den});
        q = {q[14:0], 1'b1};
      end else begin
        r = r2[31:0];
        q = {q[14:0], 1'b0};
      end
    end
    return done ? {rem, quo} : {r, q};
  endfunction

  // stage 2 logic
  always_comb begin
    logic [TRIG_AW-1:0] k;
    logic [31:0] ent;
    logic signed [15:0] s, c;
    logic signed [26:0] pa, pb;
    logic [16:0] am;
    logic signed [32:0] el, lt;
    k   = s1_q.spin_angle[15 -: TRIG_AW];
    ent = TRIG_ROM[k[TRIG_QW-1:0]];
    s   = ent[31:16];
    c   = ent[15:0];
    case (k[TRIG_AW-1 -: 2])
      2'd0: begin s2_sn_d = s;  s2_cs_d = c;  end
      2'd1: begin s2_sn_d = c;  s2_cs_d = -s; end
      2'd2: begin s2_sn_d = -s; s2_cs_d = -c; end
      default: begin s2_sn_d = -c; s2_cs_d = s; end
    endcase
    for (int j = 0; j < 3; j++) begin
      pa = 27'($signed(s1_q.now_position[16*j +: 16])) * 27'($signed({1'b0, f_eff}));
      pb = 27'($signed(s1_q.prev_position[16*j +: 16]))
           * 27'($signed({1'b0, 9'd256 - f_eff}));
      s2_pos_d[j] = 16'(rnd_shift(64'(pa) + 64'(pb), 8));
    end
    am = 17'(s1_q.opacity) * 17'(f_eff) + 17'd128;
    s2_alpha_d = (s1_q.fading_in && !additive_q) ? am[15:8] : s1_q.opacity;
    el = $signed({1'b0, cur_q}) - $signed({1'b0, s1_q.birth_time});
    lt = $signed({1'b0, s1_q.death_time}) - $signed({1'b0, s1_q.birth_time});
    s2_rem_d  = el[31:0];
    s2_den_d  = lt[31:0];
    s2_quo_d  = '0;
    s2_done_d = 1'b1;
    if (lt <= 33'sd0) begin
      s2_quo_d = 16'hffff;
    end else if (el < 33'sd0) begin
      s2_quo_d = 16'h0000;
    end else if (el >= lt) begin
      s2_quo_d = 16'hffff;
    end else begin
      s2_done_d = 1'b0;
    end
  end

  // stages 3 to 6 logic
  always_comb begin
    logic signed [15:0] upc, rtc;
    logic signed [32:0] u, r;
    logic signed [63:0] ra, rb;
    logic [47:0] dq;
    for (int j = 0; j < 3; j++) begin
      upc = up_q[16*j +: 16];
      rtc = right_q[16*j +: 16];
      s3_rs_d[j] = 32'(rtc) * 32'(s2_sn_q);
      s3_uc_d[j] = 32'(upc) * 32'(s2_cs_q);
      s3_rc_d[j] = 32'(rtc) * 32'(s2_cs_q);
      s3_us_d[j] = 32'(upc) * 32'(s2_sn_q);
      u = 33'(s3_uc_q[j]) - 33'(s3_rs_q[j]);
      r = 33'(s3_rc_q[j]) + 33'(s3_us_q[j]);
      s4_sum_d[j] = 34'(u) + 34'(r);
      s4_dif_d[j] = 34'(u) - 34'(r);
      s5_a_d[j] = 51'(s4_sum_q[j]) * 51'($signed({1'b0, s4_size_q}));
      s5_b_d[j] = 51'(s4_dif_q[j]) * 51'($signed({1'b0, s4_size_q}));
      ra = rnd_shift(64'(s5_a_q[j]), 32);
      rb = rnd_shift(64'(s5_b_q[j]), 32);
      s6_c_d[0][j] = sat16(64'(s5_pos_q[j]) + ra);
      s6_c_d[1][j] = sat16(64'(s5_pos_q[j]) + rb);
      s6_c_d[2][j] = sat16(64'(s5_pos_q[j]) - ra);
      s6_c_d[3][j] = sat16(64'(s5_pos_q[j]) - rb);
    end
    {s3_rem_d, s3_quo_d} = div4(s2_rem_q, s2_quo_q, s2_den_q, s2_done_q);
    {s4_rem_d, s4_quo_d} = div4(s3_rem_q, s3_quo_q, s3_den_q, s3_done_q);
    {s5_rem_d, s5_quo_d} = div4(s4_rem_q, s4_quo_q, s4_den_q, s4_done_q);
    dq = div4(s5_rem_q, s5_quo_q, s5_den_q, s5_done_q);
    s6_life_d = dq[15:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q        <= '0;
      right_q     <= '0;
      interp_q    <= 9'd256;
      cur_q       <= '0;
      additive_q  <= 1'b0;
      v_q         <= '0;
      exp_valid_q <= 1'b0;
      cnt_q       <= '0;
      quad_cnt_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_UP_VECTOR:     up_q       <= cfg_data_i;
          REG_RIGHT_VECTOR:  right_q    <= cfg_data_i;
          REG_INTERP_FACTOR: interp_q   <= cfg_data_i[8:0];
          REG_CURRENT_TIME:  cur_q      <= cfg_data_i[31:0];
          REG_ADDITIVE_MODE: additive_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_req_i.final_particle) begin
          quad_cnt_q <= '0;
        end else if (in_live) begin
          quad_cnt_q <= (quad_cnt_q == 16'(MAX_QUADS - 1)) ? '0 : quad_cnt_q + 16'd1;
        end
      end
      if (en[1]) begin
        v_q[1] <= in_acc && in_live;
      end
      for (int i = 2; i <= 6; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
      if (exp_free) begin
        exp_valid_q <= v_q[6];
        cnt_q       <= '0;
      end else if (exp_valid_q && !out_stall_i) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_q     <= in_req_i;
      s1_idx_q <= quad_cnt_q;
    end
    if (en[2]) begin
      s2_pos_q   <= s2_pos_d;
      s2_sn_q    <= s2_sn_d;
      s2_cs_q    <= s2_cs_d;
      s2_alpha_q <= s2_alpha_d;
      s2_size_q  <= s1_q.half_size;
      s2_rgb_q   <= s1_q.colour_rgb;
      s2_idx_q   <= s1_idx_q;
      s2_rem_q   <= s2_rem_d;
      s2_den_q   <= s2_den_d;
      s2_quo_q   <= s2_quo_d;
      s2_done_q  <= s2_done_d;
    end
    if (en[3]) begin
      s3_rs_q    <= s3_rs_d;
      s3_uc_q    <= s3_uc_d;
      s3_rc_q    <= s3_rc_d;
      s3_us_q    <= s3_us_d;
      s3_pos_q   <= s2_pos_q;
      s3_alpha_q <= s2_alpha_q;
      s3_size_q  <= s2_size_q;
      s3_rgb_q   <= s2_rgb_q;
      s3_idx_q   <= s2_idx_q;
      s3_rem_q   <= s3_rem_d;
      s3_den_q   <= s2_den_q;
      s3_quo_q   <= s3_quo_d;
      s3_done_q  <= s2_done_q;
    end
    if (en[4]) begin
      s4_sum_q   <= s4_sum_d;
      s4_dif_q   <= s4_dif_d;
      s4_pos_q   <= s3_pos_q;
      s4_alpha_q <= s3_alpha_q;
      s4_size_q  <= s3_size_q;
      s4_rgb_q   <= s3_rgb_q;
      s4_idx_q   <= s3_idx_q;
      s4_rem_q   <= s4_rem_d;
      s4_den_q   <= s3_den_q;
      s4_quo_q   <= s4_quo_d;
      s4_done_q  <= s3_done_q;
    end
    if (en[5]) begin
      s5_a_q     <= s5_a_d;
      s5_b_q     <= s5_b_d;
      s5_pos_q   <= s4_pos_q;
      s5_alpha_q <= s4_alpha_q;
      s5_rgb_q   <= s4_rgb_q;
      s5_idx_q   <= s4_idx_q;
      s5_rem_q   <= s5_rem_d;
      s5_den_q   <= s4_den_q;
      s5_quo_q   <= s5_quo_d;
      s5_done_q  <= s4_done_q;
    end
    if (en[6]) begin
      s6_c_q     <= s6_c_d;
      s6_alpha_q <= s5_alpha_q;
      s6_rgb_q   <= s5_rgb_q;
      s6_idx_q   <= s5_idx_q;
      s6_life_q  <= s6_life_d;
    end
    if (exp_free) begin
      ex_c_q     <= s6_c_q;
      ex_alpha_q <= s6_alpha_q;
      ex_rgb_q   <= s6_rgb_q;
      ex_idx_q   <= s6_idx_q;
      ex_life_q  <= s6_life_q;
    end
  end

  // vertex output
  assign out_valid_o = exp_valid_q;
  always_comb begin
    out_rsp_o.corner_x      = ex_c_q[cnt_q][0];
    out_rsp_o.corner_y      = ex_c_q[cnt_q][1];
    out_rsp_o.corner_z      = ex_c_q[cnt_q][2];
    out_rsp_o.tex_s         = cnt_q[1];
    out_rsp_o.tex_t         = cnt_q[1] ^ cnt_q[0];
    out_rsp_o.vertex_rgb    = ex_rgb_q;
    out_rsp_o.vertex_alpha  = ex_alpha_q;
    out_rsp_o.life_fraction = ex_life_q;
    out_rsp_o.quad_last     = (cnt_q == 2'd3);
    out_rsp_o.quad_index    = ex_idx_q;
  end

  `RBQE_ASSERT_NEXT(a_frame_restart, in_acc && in_req_i.final_particle, quad_cnt_q == '0,
    "quad count not restarted after final particle")
  `RBQE_ASSERT_NEXT(a_corner_walk, exp_valid_q && !out_stall_i && (cnt_q != 2'd3),
    exp_valid_q && (cnt_q == $past(cnt_q) + 2'd1), "corner sequence broken")
  `RBQE_ASSERT_NEXT(a_hold_on_stall, exp_valid_q && out_stall_i,
    exp_valid_q && $stable(cnt_q), "vertex dropped under stall")

endmodule

@@ tb/sv/rotated_billboard_quad_expander_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_billboard_quad_expander_checker
// watches the request, vertex and register channels, predicts the four corner
// vertices of every live particle and compares them in order
// ----------------------------------------------------------------------------
module rotated_billboard_quad_expander_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  rbqe_pkg::in_req_t               in_req_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  rbqe_pkg::out_rsp_t              out_rsp_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  rbqe_pkg::cfg_idx_t              cfg_index_i,
  input  logic [rbqe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import rbqe_pkg::*;

  localparam int TAB_N = 1024;
  localparam longint unsigned QTR_TURN_Q30 = 64'd1686629713;

  shortint sin_q14[TAB_N];
  shortint cos_q14[TAB_N];

  logic [47:0] cam_up;
  logic [47:0] cam_right;
  logic [8:0]  blend_f;
  logic [31:0] now_ms;
  logic        additive;
  logic [15:0] quad_count;

  out_rsp_t vertex_queue[$];
  int       fails;

  assign fail_count_o = fails;
  assign pending_o    = vertex_queue.size();

  function automatic longint round_shift(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint sext16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  initial begin
    longint unsigned x, ts, tc;
    longint ss, cs, sv, cv;
    int q, r;
    for (int k = 0; k < TAB_N; k++) begin
      q = (4 * k) / TAB_N;
      r = 4 * k - q * TAB_N;
      x = (QTR_TURN_Q30 * longint'(r)) / TAB_N;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      cs = longint'(tc);
      for (int n = 1; n <= 8; n++) begin
        ts = ((ts * x) >> 30) / (2 * n);
        ts = ((ts * x) >> 30) / (2 * n + 1);
        tc = ((tc * x) >> 30) / (2 * n - 1);
        tc = ((tc * x) >> 30) / (2 * n);
        if (n % 2 == 1) begin
          ss -= longint'(ts);
          cs -= longint'(tc);
        end else begin
          ss += longint'(ts);
          cs += longint'(tc);
        end
      end
      case (q)
        0: begin sv = ss;  cv = cs;  end
        1: begin sv = cs;  cv = -ss; end
        2: begin sv = -ss; cv = -cs; end
        default: begin sv = -cs; cv = ss; end
      endcase
      sin_q14[k] = shortint'(round_shift(sv, 16));
      cos_q14[k] = shortint'(round_shift(cv, 16));
    end
  end

  task automatic expand_particle(in_req_t p);
    longint f, sn, cs, el, lt, off, su, sr;
    longint pos[3], uq[3], rq[3];
    logic [7:0]  alpha;
    logic [15:0] life;
    logic [15:0] crd[3];
    out_rsp_t v;
    int k;
    f = (blend_f > 256) ? 256 : longint'(blend_f);
    if (!(longint'(p.death_time) > longint'(now_ms))) begin
      if (p.final_particle) quad_count = '0;
      return;
    end
    k = p.spin_angle >> 6;
    sn = sin_q14[k];
    cs = cos_q14[k];
    for (int j = 0; j < 3; j++) begin
      pos[j] = round_shift(sext16(p.now_position[16*j +: 16]) * f
                           + sext16(p.prev_position[16*j +: 16]) * (256 - f), 8);
      uq[j] = -sext16(cam_right[16*j +: 16]) * sn + sext16(cam_up[16*j +: 16]) * cs;
      rq[j] = sext16(cam_right[16*j +: 16]) * cs + sext16(cam_up[16*j +: 16]) * sn;
    end
    alpha = (p.fading_in && !additive) ? 8'((p.opacity * f + 128) >> 8) : p.opacity;
    el = longint'(now_ms) - longint'(p.birth_time);
    lt = longint'(p.death_time) - longint'(p.birth_time);
    if (lt <= 0) life = 16'hffff;
    else if (el < 0) life = 16'h0;
    else life = ((el << 16) / lt > 65535) ? 16'hffff : 16'((el << 16) / lt);
    for (int n = 0; n < 4; n++) begin
      su = (n < 2) ? 1 : -1;
      sr = (n == 0 || n == 3) ? 1 : -1;
      for (int j = 0; j < 3; j++) begin
        off = (su * uq[j] + sr * rq[j]) * longint'(p.half_size);
        crd[j] = clamp16(pos[j] + round_shift(off, 32));
      end
      v.corner_x      = crd[0];
      v.corner_y      = crd[1];
      v.corner_z      = crd[2];
      v.tex_s         = (n >= 2);
      v.tex_t         = (n == 1 || n == 2);
      v.vertex_rgb    = p.colour_rgb;
      v.vertex_alpha  = alpha;
      v.life_fraction = life;
      v.quad_last     = (n == 3);
      v.quad_index    = quad_count;
      vertex_queue = {vertex_queue, v};
    end
    quad_count = quad_count + 16'd1;
    if (p.final_particle) quad_count = '0;
  endtask

  task automatic compare_vertex(out_rsp_t got);
    out_rsp_t exp_v;
    if (vertex_queue.size() == 0) begin
      $error("vertex with no particle pending");
      fails++;
      return;
    end
    exp_v = vertex_queue.pop_front();
    if (got.corner_x !== exp_v.corner_x) begin
      $error("corner_x exp %0h got %0h", exp_v.corner_x, got.corner_x); fails++;
    end
    if (got.corner_y !== exp_v.corner_y) begin
      $error("corner_y exp %0h got %0h", exp_v.corner_y, got.corner_y); fails++;
    end
    if (got.corner_z !== exp_v.corner_z) begin
      $error("corner_z exp %0h got %0h", exp_v.corner_z, got.corner_z); fails++;
    end
    if (got.tex_s !== exp_v.tex_s) begin
      $error("tex_s exp %0h got %0h", exp_v.tex_s, got.tex_s); fails++;
    end
    if (got.tex_t !== exp_v.tex_t) begin
      $error("tex_t exp %0h got %0h", exp_v.tex_t, got.tex_t); fails++;
    end
    if (got.vertex_rgb !== exp_v.vertex_rgb) begin
      $error("vertex_rgb exp %0h got %0h", exp_v.vertex_rgb, got.vertex_rgb); fails++;
    end
    if (got.vertex_alpha !== exp_v.vertex_alpha) begin
      $error("vertex_alpha exp %0h got %0h", exp_v.vertex_alpha, got.vertex_alpha); fails++;
    end
    if (got.life_fraction !== exp_v.life_fraction) begin
      $error("life_fraction exp %0h got %0h", exp_v.life_fraction, got.life_fraction);
      fails++;
    end
    if (got.quad_last !== exp_v.quad_last) begin
      $error("quad_last exp %0h got %0h", exp_v.quad_last, got.quad_last); fails++;
    end
    if (got.quad_index !== exp_v.quad_index) begin
      $error("quad_index exp %0h got %0h", exp_v.quad_index, got.quad_index); fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_up     = '0;
      cam_right  = '0;
      blend_f    = 9'd256;
      now_ms     = '0;
      additive   = 1'b0;
      quad_count = '0;
      vertex_queue.delete();
    end else begin
      if (out_valid_i && !out_stall_i) compare_vertex(out_rsp_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_UP_VECTOR:     cam_up    = cfg_data_i[47:0];
          REG_RIGHT_VECTOR:  cam_right = cfg_data_i[47:0];
          REG_INTERP_FACTOR: blend_f   = cfg_data_i[8:0];
          REG_CURRENT_TIME:  now_ms    = cfg_data_i[31:0];
          REG_ADDITIVE_MODE: additive  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expand_particle(in_req_i);
    end
  end

endmodule

@@ tb/sv/rotated_billboard_quad_expander_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_billboard_quad_expander_tb
// drives directed and random particle requests with bursty input and a
// patterned output stall, sweeps camera and timing registers between phases,
// and reports the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module rotated_billboard_quad_expander_tb;
  import rbqe_pkg::*;

  localparam cfg_idx_t REG_UNMAPPED = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_req_t               in_req_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_rsp_t              out_rsp_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  cfg_idx_t              cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int          fail_count;
  int          pending;
  int          burst_left;
  logic [31:0] stim_now;
  logic        hold_go;

  rotated_billboard_quad_expander u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  rotated_billboard_quad_expander_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_i   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int cyc;
    int mode;
    int hold_cnt;
    out_stall_i = 1'b0;
    cyc = 0;
    mode = 0;
    hold_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_go && hold_cnt < 300) begin
        hold_cnt++;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= cyc[0];
          default: out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_CURRENT_TIME) stim_now = data[31:0];
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_particle(in_req_t p, bit bursty);
    if (bursty && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_req_i   <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic end_requests();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_req_t rand_particle(int live_pct);
    in_req_t p;
    p.now_position   = 48'({$urandom, $urandom});
    p.prev_position  = 48'({$urandom, $urandom});
    p.spin_angle     = 16'($urandom);
    p.half_size      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
    p.colour_rgb     = 24'($urandom);
    p.opacity        = 8'($urandom);
    p.fading_in      = 1'($urandom);
    p.final_particle = ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 99) < live_pct) begin
      p.death_time = stim_now + $urandom_range(1, 5000);
      case ($urandom_range(0, 4))
        0: p.birth_time = p.death_time;
        1: p.birth_time = p.death_time + $urandom_range(1, 500);
        2: p.birth_time = stim_now + $urandom_range(0, 300);
        default: p.birth_time = stim_now - $urandom_range(0, 5000);
      endcase
    end else begin
      p.birth_time = $urandom;
      p.death_time = ($urandom_range(0, 1) == 0) ? stim_now - $urandom_range(0, 100)
                                                  : 32'($urandom);
    end
    return p;
  endfunction

  function automatic in_req_t base_particle();
    in_req_t p;
    p = '0;
    p.half_size  = 16'h0100;
    p.colour_rgb = 24'h123456;
    p.opacity    = 8'hff;
    p.birth_time = stim_now - 32'd100;
    p.death_time = stim_now + 32'd100;
    return p;
  endfunction

  initial begin
    in_req_t p;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_UP_VECTOR;
    cfg_data_i  = '0;
    burst_left  = 0;
    stim_now    = '0;
    hold_go     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and special cases
    write_reg(REG_UP_VECTOR, {16'h0000, 16'h4000, 16'h0000});
    write_reg(REG_RIGHT_VECTOR, {16'h0000, 16'h0000, 16'h4000});
    write_reg(REG_CURRENT_TIME, 48'd100000);
    write_reg(REG_INTERP_FACTOR, 48'd128);
    write_reg(REG_ADDITIVE_MODE, 48'd0);
    write_reg(REG_UNMAPPED, {16'hffff, 32'hffffffff});
    p = base_particle(); send_particle(p, 1'b0);
    p = base_particle(); p.spin_angle = 16'hffff; p.fading_in = 1'b1;
    send_particle(p, 1'b0);
    p = base_particle(); p.spin_angle = 16'h4000; p.opacity = 8'h80; p.fading_in = 1'b1;
    send_particle(p, 1'b0);
    p = base_particle(); p.now_position = {3{16'h7fff}}; p.prev_position = {3{16'h7fff}};
    p.half_size = 16'hffff; p.spin_angle = 16'h2000; send_particle(p, 1'b0);
    p = base_particle(); p.now_position = {3{16'h8000}}; p.prev_position = {3{16'h8000}};
    p.half_size = 16'hffff; p.spin_angle = 16'h8000; send_particle(p, 1'b0);
    p = base_particle(); p.now_position = {3{16'h7fff}}; p.prev_position = {3{16'h8000}};
    send_particle(p, 1'b0);
    p = base_particle(); p.birth_time = p.death_time; send_particle(p, 1'b0);
    p = base_particle(); p.birth_time = p.death_time + 32'd5; send_particle(p, 1'b0);
    p = base_particle(); p.birth_time = stim_now + 32'd50; send_particle(p, 1'b0);
    p = base_particle(); p.death_time = stim_now; send_particle(p, 1'b0);
    p = base_particle(); p.death_time = 32'd0; p.final_particle = 1'b1;
    send_particle(p, 1'b0);
    p = base_particle(); p.colour_rgb = 24'hffffff; p.final_particle = 1'b1;
    send_particle(p, 1'b0);
    p = base_particle(); p.birth_time = 32'hffffffff; p.death_time = 32'hffffffff;
    send_particle(p, 1'b0);
    end_requests();
    drain();

    write_reg(REG_INTERP_FACTOR, 48'd511);
    write_reg(REG_ADDITIVE_MODE, 48'd1);
    write_reg(REG_UP_VECTOR, {16'h8000, 16'h7fff, 16'h8000});
    write_reg(REG_RIGHT_VECTOR, {16'h7fff, 16'h8000, 16'h7fff});
    p = base_particle(); p.fading_in = 1'b1; p.half_size = 16'hffff;
    p.now_position = {16'h0123, 16'hfedc, 16'h7fff}; send_particle(p, 1'b0);
    end_requests();
    drain();
    write_reg(REG_INTERP_FACTOR, 48'd0);
    write_reg(REG_ADDITIVE_MODE, 48'd0);
    p = base_particle(); p.fading_in = 1'b1; p.prev_position = {3{16'h7fff}};
    send_particle(p, 1'b0);
    end_requests();
    drain();
    write_reg(REG_CURRENT_TIME, 48'hffffffff);
    p = base_particle(); p.death_time = 32'hffffffff; send_particle(p, 1'b0);
    end_requests();
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_UP_VECTOR, 48'({$urandom, $urandom}));
      write_reg(REG_RIGHT_VECTOR, 48'({$urandom, $urandom}));
      write_reg(REG_INTERP_FACTOR, (ph == 0) ? 48'd256 : 48'($urandom_range(0, 300)));
      write_reg(REG_CURRENT_TIME, (ph == 1) ? 48'd0 : 48'($urandom_range(10000, 32'h7fffffff)));
      write_reg(REG_ADDITIVE_MODE, 48'(ph % 2));
      if (ph == 2) hold_go = 1'b1;
      for (int i = 0; i < 52; i++) send_particle(rand_particle(80), 1'b1);
      end_requests();
      drain();
    end

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(12 * 100000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
